// File: design/cov_pkg.sv
package cov_pkg;

    localparam int ACTION_W = 2;
    localparam int CONTIG_W = 10;
    localparam int SCAF_W   = 16;
    localparam int POS_W    = 16;
    localparam int COUNT_W  = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PAIR  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PAIR,
        OP_QUERY
    } t_op;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC,
        BK_WRB
    } t_back_state;

    // classified command as it travels from front to back
    typedef struct packed {
        t_op                 op;
        logic [CONTIG_W-1:0] contig_a;
        logic [CONTIG_W-1:0] contig_b;
        logic                a_ok;      // contig_a inside the table
        logic [SCAF_W-1:0]   scaffold;
        logic [POS_W-1:0]    pos;
        logic                fwd;
        logic [COUNT_W-1:0]  win;       // winning join count
        logic                a_fwd;     // winner has a forward
        logic                b_fwd;     // winner has b forward
    } t_cmd;

endpackage

// File: design/cov_if.sv
interface cov_in_if
    import cov_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CONTIG_W-1:0] contig_a;
    logic [CONTIG_W-1:0] contig_b;
    logic [SCAF_W-1:0]   scaffold_id;
    logic [POS_W-1:0]    scaffold_pos;
    logic                forward;
    logic [COUNT_W-1:0]  count_ff;
    logic [COUNT_W-1:0]  count_fr;
    logic [COUNT_W-1:0]  count_rf;
    logic [COUNT_W-1:0]  count_rr;

    modport source (
        output valid, action, contig_a, contig_b, scaffold_id, scaffold_pos, forward,
               count_ff, count_fr, count_rf, count_rr,
        input  ready
    );
    modport sink (
        input  valid, action, contig_a, contig_b, scaffold_id, scaffold_pos, forward,
               count_ff, count_fr, count_rf, count_rr,
        output ready
    );
endinterface

interface cov_out_if
    import cov_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CONTIG_W-1:0] queried_contig;
    logic                entry_valid;
    logic                final_forward;
    logic                changed;

    modport source (
        output valid, queried_contig, entry_valid, final_forward, changed,
        input  ready
    );
    modport sink (
        input  valid, queried_contig, entry_valid, final_forward, changed,
        output ready
    );
endinterface

// File: design/cov_front.sv
module cov_front
    import cov_pkg::*;
#(
    parameter int MAX_CONTIGS = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cov_in_if.sink   i_in,
    input  logic     i_clearing,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_ready
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;
    logic keep;
    logic a_ok;
    logic b_ok;
    logic ff_top;
    logic fr_top;
    logic rf_top;

    assign i_in.ready  = !i_clearing && (!r_valid || i_cmd_ready);
    assign accept      = i_in.valid && i_in.ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    assign a_ok = 32'(i_in.contig_a) < 32'(MAX_CONTIGS);
    assign b_ok = 32'(i_in.contig_b) < 32'(MAX_CONTIGS);

    // winner pick, ties resolved ff, fr, rf, rr
    assign ff_top = (i_in.count_ff >= i_in.count_fr) && (i_in.count_ff >= i_in.count_rf)
                 && (i_in.count_ff >= i_in.count_rr);
    assign fr_top = (i_in.count_fr >= i_in.count_ff) && (i_in.count_fr >= i_in.count_rf)
                 && (i_in.count_fr >= i_in.count_rr);
    assign rf_top = (i_in.count_rf >= i_in.count_ff) && (i_in.count_rf >= i_in.count_fr)
                 && (i_in.count_rf >= i_in.count_rr);

    always_comb begin
        n_cmd.contig_a = i_in.contig_a;
        n_cmd.contig_b = i_in.contig_b;
        n_cmd.a_ok     = a_ok;
        n_cmd.scaffold = i_in.scaffold_id;
        n_cmd.pos      = i_in.scaffold_pos;
        n_cmd.fwd      = i_in.forward;
        if (ff_top) begin
            n_cmd.win = i_in.count_ff; n_cmd.a_fwd = 1'b1; n_cmd.b_fwd = 1'b1;
        end else if (fr_top) begin
            n_cmd.win = i_in.count_fr; n_cmd.a_fwd = 1'b1; n_cmd.b_fwd = 1'b0;
        end else if (rf_top) begin
            n_cmd.win = i_in.count_rf; n_cmd.a_fwd = 1'b0; n_cmd.b_fwd = 1'b1;
        end else begin
            n_cmd.win = i_in.count_rr; n_cmd.a_fwd = 1'b0; n_cmd.b_fwd = 1'b0;
        end
        case (i_in.action)
            ACT_LOAD: begin
                n_cmd.op = OP_LOAD;
                keep     = a_ok;
            end
            ACT_PAIR: begin
                n_cmd.op = OP_PAIR;
                keep     = a_ok && b_ok && (i_in.contig_a < i_in.contig_b);
            end
            ACT_QUERY: begin
                n_cmd.op = OP_QUERY;
                keep     = 1'b1;
            end
            default: begin
                n_cmd.op = OP_QUERY;
                keep     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: design/cov_fifo.sv
module cov_fifo
    import cov_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_can_push,
    output logic o_pop_valid,
    output t_cmd o_pop_data,
    input  logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_can_push  = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_pop_valid = r_count != '0;
    assign o_pop_data  = r_q[r_rd_ptr];
    assign do_push     = i_push && o_can_push;
    assign do_pop      = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: design/cov_back.sv
module cov_back
    import cov_pkg::*;
#(
    parameter int MAX_CONTIGS = 1024,
    parameter int TALLY_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_clearing,
    cov_out_if.source o_out
);

    localparam int IDX_W = (MAX_CONTIGS > 1) ? $clog2(MAX_CONTIGS) : 1;

    // entry table, one write port and two registered read ports
    logic                   r_mem_valid [MAX_CONTIGS];
    logic [SCAF_W-1:0]      r_mem_scaf  [MAX_CONTIGS];
    logic [POS_W-1:0]       r_mem_pos   [MAX_CONTIGS];
    logic                   r_mem_orig  [MAX_CONTIGS];
    logic [TALLY_WIDTH-1:0] r_mem_agr   [MAX_CONTIGS];
    logic [TALLY_WIDTH-1:0] r_mem_dis   [MAX_CONTIGS];

    logic                   r_a_valid, r_b_valid;
    logic [SCAF_W-1:0]      r_a_scaf, r_b_scaf;
    logic [POS_W-1:0]       r_a_pos, r_b_pos;
    logic                   r_a_orig, r_b_orig;
    logic [TALLY_WIDTH-1:0] r_a_agr, r_b_agr;
    logic [TALLY_WIDTH-1:0] r_a_dis, r_b_dis;

    t_back_state      r_state, n_state;
    logic [IDX_W-1:0] r_clr_idx, n_clr_idx;
    t_cmd             r_cmd;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_idx_a, rd_idx_b;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic                   wr_valid;
    logic [SCAF_W-1:0]      wr_scaf;
    logic [POS_W-1:0]       wr_pos;
    logic                   wr_orig;
    logic [TALLY_WIDTH-1:0] wr_agr, wr_dis;

    logic                   r_out_valid;
    logic [CONTIG_W-1:0]    r_out_contig;
    logic                   r_out_entry_valid;
    logic                   r_out_final;
    logic                   r_out_changed;
    logic                   out_load;
    logic                   out_free;
    logic                   q_valid, q_final;

    logic                   a_first;
    logic                   a_agree, b_agree;
    logic [TALLY_WIDTH:0]   sum_a, sum_b;
    logic [TALLY_WIDTH-1:0] sat_a, sat_b;
    logic                   pair_ok;

    assign o_clearing = r_state == BK_CLEAR;
    assign out_free   = !r_out_valid || o_out.ready;

    // vote direction follows position order within the scaffold
    assign a_first = r_a_pos < r_b_pos;
    assign a_agree = r_cmd.a_fwd == a_first;
    assign b_agree = r_cmd.b_fwd == a_first;
    assign pair_ok = r_a_valid && r_b_valid && (r_a_scaf == r_b_scaf);

    assign sum_a = {1'b0, (a_agree ? r_a_agr : r_a_dis)} + (TALLY_WIDTH + 1)'(r_cmd.win);
    assign sum_b = {1'b0, (b_agree ? r_b_agr : r_b_dis)} + (TALLY_WIDTH + 1)'(r_cmd.win);
    assign sat_a = sum_a[TALLY_WIDTH] ? '1 : sum_a[TALLY_WIDTH-1:0];
    assign sat_b = sum_b[TALLY_WIDTH] ? '1 : sum_b[TALLY_WIDTH-1:0];

    // decision of a query
    assign q_valid = r_cmd.a_ok && r_a_valid;
    assign q_final = (r_a_agr == r_a_dis) ? r_a_orig : (r_a_dis < r_a_agr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_idx_a  = IDX_W'(i_cmd.contig_a);
        rd_idx_b  = IDX_W'(i_cmd.contig_b);
        wr_en     = 1'b0;
        wr_idx    = IDX_W'(r_cmd.contig_a);
        wr_valid  = 1'b1;
        wr_scaf   = r_a_scaf;
        wr_pos    = r_a_pos;
        wr_orig   = r_a_orig;
        wr_agr    = r_a_agr;
        wr_dis    = r_a_dis;
        out_load  = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                wr_en     = 1'b1;
                wr_idx    = r_clr_idx;
                wr_valid  = 1'b0;
                wr_scaf   = '0;
                wr_pos    = '0;
                wr_orig   = 1'b0;
                wr_agr    = '0;
                wr_dis    = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(MAX_CONTIGS - 1)) begin
                    n_clr_idx = '0;
                    n_state   = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_LOAD) begin
                        // load seeds one vote for the given orientation
                        wr_en   = 1'b1;
                        wr_idx  = IDX_W'(i_cmd.contig_a);
                        wr_scaf = i_cmd.scaffold;
                        wr_pos  = i_cmd.pos;
                        wr_orig = i_cmd.fwd;
                        wr_agr  = TALLY_WIDTH'(i_cmd.fwd);
                        wr_dis  = TALLY_WIDTH'(!i_cmd.fwd);
                    end else begin
                        rd_en   = 1'b1;
                        n_state = BK_EXEC;
                    end
                end
            end
            BK_EXEC: begin
                if (r_cmd.op == OP_QUERY) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = BK_IDLE;
                    end
                end else if (pair_ok) begin
                    wr_en   = 1'b1;
                    wr_agr  = a_agree ? sat_a : r_a_agr;
                    wr_dis  = a_agree ? r_a_dis : sat_a;
                    n_state = BK_WRB;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_WRB: begin
                wr_en   = 1'b1;
                wr_idx  = IDX_W'(r_cmd.contig_b);
                wr_scaf = r_b_scaf;
                wr_pos  = r_b_pos;
                wr_orig = r_b_orig;
                wr_agr  = b_agree ? sat_b : r_b_agr;
                wr_dis  = b_agree ? r_b_dis : sat_b;
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_valid[wr_idx] <= wr_valid;
            r_mem_scaf[wr_idx]  <= wr_scaf;
            r_mem_pos[wr_idx]   <= wr_pos;
            r_mem_orig[wr_idx]  <= wr_orig;
            r_mem_agr[wr_idx]   <= wr_agr;
            r_mem_dis[wr_idx]   <= wr_dis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_a_valid <= r_mem_valid[rd_idx_a];
            r_a_scaf  <= r_mem_scaf[rd_idx_a];
            r_a_pos   <= r_mem_pos[rd_idx_a];
            r_a_orig  <= r_mem_orig[rd_idx_a];
            r_a_agr   <= r_mem_agr[rd_idx_a];
            r_a_dis   <= r_mem_dis[rd_idx_a];
            r_b_valid <= r_mem_valid[rd_idx_b];
            r_b_scaf  <= r_mem_scaf[rd_idx_b];
            r_b_pos   <= r_mem_pos[rd_idx_b];
            r_b_orig  <= r_mem_orig[rd_idx_b];
            r_b_agr   <= r_mem_agr[rd_idx_b];
            r_b_dis   <= r_mem_dis[rd_idx_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_contig      <= r_cmd.contig_a;
            r_out_entry_valid <= q_valid;
            r_out_final       <= q_valid && q_final;
            r_out_changed     <= q_valid && (q_final != r_a_orig);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.queried_contig = r_out_contig;
    assign o_out.entry_valid    = r_out_entry_valid;
    assign o_out.final_forward  = r_out_final;
    assign o_out.changed        = r_out_changed;

endmodule

// File: design/contig_orientation_vote_table.sv
// Query path: front register, queue, table read, then the decision loads the output register.
// Flow: the front takes at most one transfer a cycle, while not clearing and its register can
//   move on. Back end: a load is done in idle; a query waits in exec for the output register;
//   a pair reads both entries, then one write port stores a and b in turn (exec, write-back),
//   and one that fails the valid or scaffold check stops in exec; front drops never reach it.
// Reset: synchronous, active low; afterwards a clearing pass sweeps the valid bits of all
//   MAX_CONTIGS entries, and no input transfer is taken until it ends.
module contig_orientation_vote_table
    import cov_pkg::*;
#(
    parameter int MAX_CONTIGS = 1024,
    parameter int TALLY_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cov_in_if.sink    i_in,
    cov_out_if.source o_out
);

    // front -> queue
    logic front_valid;
    t_cmd front_cmd;
    logic q_can_push;

    // queue -> back
    logic q_pop_valid;
    t_cmd q_pop_data;
    logic back_pop;

    // back holds the input off while it sweeps the table
    logic clearing;

    // Front: takes the transfer, checks index range and a < b, picks the winning
    // join count. Unused actions and pairs that can never vote are dropped here.
    cov_front #(
        .MAX_CONTIGS (MAX_CONTIGS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_clearing  (clearing),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (q_can_push)
    );

    // Short queue decouples the front from the multi-cycle table work.
    cov_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .i_push_data (front_cmd),
        .o_can_push  (q_can_push),
        .o_pop_valid (q_pop_valid),
        .o_pop_data  (q_pop_data),
        .i_pop       (back_pop)
    );

    // Back: owns the entry table. Loads write directly; pairs do read, check
    // scaffold and valid bits, then saturating tally updates of a and b; queries
    // decide orientation into the output register.
    cov_back #(
        .MAX_CONTIGS (MAX_CONTIGS),
        .TALLY_WIDTH (TALLY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_pop_valid),
        .i_cmd       (q_pop_data),
        .o_cmd_pop   (back_pop),
        .o_clearing  (clearing),
        .o_out       (o_out)
    );

endmodule
